/* rtl/pia_pkg.sv */
// Shared types and constants for the port idle auto-off block.
package pia_pkg;

    localparam int IDLE_W  = 24;
    localparam int POWER_W = 12;
    localparam int RUN_W   = 3;
    localparam int WAIT_W  = 8;
    localparam int MASK_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    localparam logic [IDLE_W-1:0] IDLE_MAX  = {IDLE_W{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX  = {WAIT_W{1'b1}};
    localparam logic [RUN_W-1:0]  RUN_CLEAR = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RST   = 24'd3600;
    localparam logic [MASK_W-1:0]  ENABLE_MASK_RST  = 3'd7;
    localparam logic [POWER_W-1:0] DC_THRESH_RST    = 12'd1;
    localparam logic [POWER_W-1:0] AC_THRESH_RST    = 12'd5;
    localparam logic [WAIT_W-1:0]  FULL_WAIT_RST    = 8'd60;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_USB_IDLE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_IDLE_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AC_IDLE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AC_THRESHOLD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_WAIT      = 3'd6;

    // Bits of the enable mask.
    localparam int EN_USB = 0;
    localparam int EN_DC  = 1;
    localparam int EN_AC  = 2;

    typedef struct packed {
        logic [IDLE_W-1:0]  usb_idle_limit;
        logic [IDLE_W-1:0]  dc_idle_limit;
        logic [IDLE_W-1:0]  ac_idle_limit;
        logic [MASK_W-1:0]  timeout_enable_mask;
        logic [POWER_W-1:0] dc_load_threshold;
        logic [POWER_W-1:0] ac_load_threshold;
        logic [WAIT_W-1:0]  full_wait_limit;
    } pia_cfg_t;

    typedef struct packed {
        logic               active;
        logic               enabled;
        logic [POWER_W-1:0] power;
        logic [POWER_W-1:0] threshold;
        logic [IDLE_W-1:0]  limit;
    } pia_port_in_t;

    typedef struct packed {
        logic               config_mode;
        logic               pack_full;
        logic               other_wake;
        logic               pv_charging;
        logic               ac_charging;
        logic               ac_active;
        logic               dc_active;
        logic               usb_active;
        logic [POWER_W-1:0] ac_power;
        logic [POWER_W-1:0] dc_power;
        logic [POWER_W-1:0] usb_power;
    } pia_item_t;

    typedef struct packed {
        logic sleep_request;
        logic clear_inverter;
        logic ac_off;
        logic dc_off;
        logic usb_off;
    } pia_result_t;

endpackage

/* rtl/port_idle_auto_off_top.sv */
// An accepted item waits in the input register; its result is then registered into
// the result register on m_tdata, and a stall at m_tready can come between.
// Throughput: one item per cycle when m_tready does not stall; an input register
// and a result register part the two sides; all port counters update together.
// Config writes take effect at the edge of the write.
// Reset (rst_n low, asynchronous) clears all counters, empties both
// registers and loads the configuration defaults.
module port_idle_auto_off_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // usb_power[11:0], dc_power[23:12], ac_power[35:24], usb_active[36],
    // dc_active[37], ac_active[38], ac_charging[39], pv_charging[40],
    // other_wake[41], pack_full[42], config_mode[43], zero fill[47:44]
    input  logic [pia_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // usb_off[0], dc_off[1], ac_off[2], clear_inverter[3],
    // sleep_request[4], zero fill[7:5]
    output logic [pia_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pia_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pia_pkg::*;

    pia_cfg_t     cfg;
    pia_item_t    in_item_reg;
    logic         in_valid_reg;
    pia_result_t  out_res_reg;
    pia_result_t  res_next;
    logic         out_valid_reg;
    logic         advance;
    logic         step;
    pia_port_in_t usb_in;
    pia_port_in_t dc_in;
    pia_port_in_t ac_in;
    logic         usb_off;
    logic         dc_off;
    logic         ac_off;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic [WAIT_W-1:0] wait_inc;
    logic         charge_only;
    logic         sleep;

    pia_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign step     = advance && !in_item_reg.config_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= pia_item_t'(s_tdata[$bits(pia_item_t)-1:0]);
        end
    end

    assign usb_in = '{active:    in_item_reg.usb_active,
                      enabled:   cfg.timeout_enable_mask[EN_USB],
                      power:     in_item_reg.usb_power,
                      threshold: cfg.dc_load_threshold,
                      limit:     cfg.usb_idle_limit};
    assign dc_in  = '{active:    in_item_reg.dc_active,
                      enabled:   cfg.timeout_enable_mask[EN_DC],
                      power:     in_item_reg.dc_power,
                      threshold: cfg.dc_load_threshold,
                      limit:     cfg.dc_idle_limit};
    assign ac_in  = '{active:    in_item_reg.ac_active,
                      enabled:   cfg.timeout_enable_mask[EN_AC],
                      power:     in_item_reg.ac_power,
                      threshold: cfg.ac_load_threshold,
                      limit:     cfg.ac_idle_limit};

    pia_port u_usb (.clk(clk), .rst_n(rst_n), .step(step), .port_in(usb_in), .off(usb_off));
    pia_port u_dc  (.clk(clk), .rst_n(rst_n), .step(step), .port_in(dc_in),  .off(dc_off));
    pia_port u_ac  (.clk(clk), .rst_n(rst_n), .step(step), .port_in(ac_in),  .off(ac_off));

    // The charge-only test sees the ports as they stand after this item's
    // switch-offs.
    assign charge_only = (in_item_reg.ac_charging || in_item_reg.pv_charging)
                       && !(in_item_reg.usb_active && !usb_off)
                       && !(in_item_reg.dc_active && !dc_off)
                       && !(in_item_reg.ac_active && !ac_off)
                       && !in_item_reg.other_wake
                       && in_item_reg.pack_full;

    assign wait_inc  = (wait_reg == WAIT_MAX) ? wait_reg : wait_reg + 1'b1;
    assign wait_next = charge_only ? wait_inc : '0;
    assign sleep     = step && charge_only && (wait_inc > cfg.full_wait_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= '0;
        end
        else if (step)
        begin
            wait_reg <= wait_next;
        end
    end

    always_comb
    begin
        res_next.usb_off        = usb_off;
        res_next.dc_off         = dc_off;
        res_next.ac_off         = ac_off;
        res_next.clear_inverter = ac_off && !in_item_reg.ac_charging;
        res_next.sleep_request  = sleep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(pia_result_t)){1'b0}}, out_res_reg};

    // An inverter clear only ever comes with an ac switch-off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.clear_inverter) |-> out_res_reg.ac_off)
        else $error("clear_inverter without ac_off");

    // A shown sleep request matches the wait count that it left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.sleep_request) |-> (wait_reg > cfg.full_wait_limit))
        else $error("sleep_request with wait count not past limit");

    // The input side stalls only when both registers are full and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

endmodule

/* rtl/pia_cfg_regs.sv */
// Configuration register file written through the config channel.
module pia_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pia_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pia_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pia_pkg::pia_cfg_t               cfg
);
    import pia_pkg::*;

    pia_cfg_t cfg_reg;
    pia_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_USB_IDLE_LIMIT: cfg_next.usb_idle_limit = cfg_data[IDLE_W-1:0];
                CFG_DC_IDLE_LIMIT:  cfg_next.dc_idle_limit  = cfg_data[IDLE_W-1:0];
                CFG_AC_IDLE_LIMIT:  cfg_next.ac_idle_limit  = cfg_data[IDLE_W-1:0];
                CFG_ENABLE_MASK:    cfg_next.timeout_enable_mask = cfg_data[MASK_W-1:0];
                CFG_DC_THRESHOLD:   cfg_next.dc_load_threshold = cfg_data[POWER_W-1:0];
                CFG_AC_THRESHOLD:   cfg_next.ac_load_threshold = cfg_data[POWER_W-1:0];
                CFG_FULL_WAIT:      cfg_next.full_wait_limit = cfg_data[WAIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.usb_idle_limit      <= IDLE_LIMIT_RST;
            cfg_reg.dc_idle_limit       <= IDLE_LIMIT_RST;
            cfg_reg.ac_idle_limit       <= IDLE_LIMIT_RST;
            cfg_reg.timeout_enable_mask <= ENABLE_MASK_RST;
            cfg_reg.dc_load_threshold   <= DC_THRESH_RST;
            cfg_reg.ac_load_threshold   <= AC_THRESH_RST;
            cfg_reg.full_wait_limit     <= FULL_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/pia_port.sv */
// Idle and load-run counters for one output port.
module pia_port (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  pia_pkg::pia_port_in_t port_in,
    output logic                  off
);
    import pia_pkg::*;

    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;
    logic [IDLE_W-1:0] idle_reg;
    logic [IDLE_W-1:0] idle_next;
    logic [IDLE_W-1:0] idle_inc;
    logic              timeout;

    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        run_next  = run_reg;
        idle_next = idle_reg;
        timeout   = 1'b0;
        priority if (!port_in.active || !port_in.enabled)
        begin
            run_next  = '0;
            idle_next = '0;
        end
        else if (port_in.power >= port_in.threshold)
        begin
            // Six loaded items in a row clear the idle count.
            if (run_reg >= RUN_CLEAR)
            begin
                run_next  = '0;
                idle_next = '0;
            end
            else
            begin
                run_next = run_reg + 1'b1;
            end
        end
        else
        begin
            run_next = '0;
            if (idle_inc > port_in.limit)
            begin
                idle_next = '0;
                timeout   = 1'b1;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
    end

    assign off = step && timeout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            idle_reg <= '0;
        end
        else if (step)
        begin
            run_reg  <= run_next;
            idle_reg <= idle_next;
        end
    end

endmodule

/* sim/pia_checker.sv */
// Checker for the port idle auto-off block: predicts each result and compares it.
`timescale 1ns / 100ps

module pia_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pia_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pia_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pia_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             results_pending
);
    import pia_pkg::*;

    localparam int RES_W = $bits(pia_result_t);

    pia_cfg_t          settings;
    logic [RUN_W-1:0]  load_run [3];
    logic [IDLE_W-1:0] idle_count [3];
    logic [WAIT_W-1:0] full_wait;
    pia_result_t       pulse_q [$];
    int                mismatches;

    // Advances the idle monitor by one tick and returns the pulses it gives.
    function automatic pia_result_t predict_tick(input pia_item_t it);
        pia_result_t       r;
        logic [2:0]        active;
        logic [2:0]        off;
        logic [POWER_W-1:0] power [3];
        logic [POWER_W-1:0] thr [3];
        logic [IDLE_W-1:0]  limit [3];
        r   = '0;
        off = '0;
        if (it.config_mode)
            return r;
        active = {it.ac_active, it.dc_active, it.usb_active};
        power[EN_USB] = it.usb_power;
        power[EN_DC]  = it.dc_power;
        power[EN_AC]  = it.ac_power;
        thr[EN_USB]   = settings.dc_load_threshold;
        thr[EN_DC]    = settings.dc_load_threshold;
        thr[EN_AC]    = settings.ac_load_threshold;
        limit[EN_USB] = settings.usb_idle_limit;
        limit[EN_DC]  = settings.dc_idle_limit;
        limit[EN_AC]  = settings.ac_idle_limit;
        for (int p = 0; p < 3; p++)
        begin
            if (!active[p] || !settings.timeout_enable_mask[p])
            begin
                load_run[p]   = '0;
                idle_count[p] = '0;
            end
            else if (power[p] >= thr[p])
            begin
                // Six loaded ticks in a row wipe the idle history.
                if (load_run[p] >= RUN_CLEAR)
                begin
                    load_run[p]   = '0;
                    idle_count[p] = '0;
                end
                else
                begin
                    load_run[p] = load_run[p] + 1'b1;
                end
            end
            else
            begin
                load_run[p] = '0;
                if (idle_count[p] != IDLE_MAX)
                    idle_count[p] = idle_count[p] + 1'b1;
                if (idle_count[p] > limit[p])
                begin
                    idle_count[p] = '0;
                    off[p]        = 1'b1;
                end
            end
        end
        r.usb_off        = off[EN_USB];
        r.dc_off         = off[EN_DC];
        r.ac_off         = off[EN_AC];
        r.clear_inverter = off[EN_AC] & ~it.ac_charging;
        // The charge-only test sees the ports as they are after this tick's switch-offs.
        if ((it.ac_charging || it.pv_charging) && (active & ~off) == 3'b000 &&
            !it.other_wake && it.pack_full)
        begin
            if (full_wait != WAIT_MAX)
                full_wait = full_wait + 1'b1;
            r.sleep_request = (full_wait > settings.full_wait_limit);
        end
        else
        begin
            full_wait = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic want, input logic got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pia_result_t got;
        pia_result_t want;
        if (!rst_n)
        begin
            settings.usb_idle_limit      = IDLE_LIMIT_RST;
            settings.dc_idle_limit       = IDLE_LIMIT_RST;
            settings.ac_idle_limit       = IDLE_LIMIT_RST;
            settings.timeout_enable_mask = ENABLE_MASK_RST;
            settings.dc_load_threshold   = DC_THRESH_RST;
            settings.ac_load_threshold   = AC_THRESH_RST;
            settings.full_wait_limit     = FULL_WAIT_RST;
            for (int p = 0; p < 3; p++)
            begin
                load_run[p]   = '0;
                idle_count[p] = '0;
            end
            full_wait  = '0;
            pulse_q.delete();
            mismatches = 0;
            fail_count      <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[RES_W-1:0];
                if (pulse_q.size() == 0)
                begin
                    $display("%0t: result expected none, got %b", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pulse_q.pop_front();
                    check_field("usb_off", want.usb_off, got.usb_off);
                    check_field("dc_off", want.dc_off, got.dc_off);
                    check_field("ac_off", want.ac_off, got.ac_off);
                    check_field("clear_inverter", want.clear_inverter, got.clear_inverter);
                    check_field("sleep_request", want.sleep_request, got.sleep_request);
                end
                if (m_tdata[OUT_DATA_W-1:RES_W] !== '0)
                begin
                    $display("%0t: fill bits expected 0, got %b", $time,
                             m_tdata[OUT_DATA_W-1:RES_W]);
                    mismatches++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_USB_IDLE_LIMIT: settings.usb_idle_limit = cfg_data[IDLE_W-1:0];
                    CFG_DC_IDLE_LIMIT:  settings.dc_idle_limit = cfg_data[IDLE_W-1:0];
                    CFG_AC_IDLE_LIMIT:  settings.ac_idle_limit = cfg_data[IDLE_W-1:0];
                    CFG_ENABLE_MASK:    settings.timeout_enable_mask = cfg_data[MASK_W-1:0];
                    CFG_DC_THRESHOLD:   settings.dc_load_threshold = cfg_data[POWER_W-1:0];
                    CFG_AC_THRESHOLD:   settings.ac_load_threshold = cfg_data[POWER_W-1:0];
                    CFG_FULL_WAIT:      settings.full_wait_limit = cfg_data[WAIT_W-1:0];
                    default:            ;
                endcase
            end
            if (s_tvalid && s_tready)
                pulse_q.push_back(predict_tick(s_tdata[$bits(pia_item_t)-1:0]));
            fail_count      <= mismatches;
            results_pending <= pulse_q.size();
        end
    end

endmodule

/* sim/tb_port_idle_auto_off_top.sv */
// Testbench top for the port idle auto-off block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_port_idle_auto_off_top;
    import pia_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int RX_HOLD_CYCLES = 100;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int POWER_MAX      = 4095;
    localparam logic [POWER_W-1:0] POWER_TOP = '1;

    // Flag byte of an item, from usb_active up to config_mode.
    localparam logic [7:0] FL_USB  = 8'h01;
    localparam logic [7:0] FL_DC   = 8'h02;
    localparam logic [7:0] FL_AC   = 8'h04;
    localparam logic [7:0] FL_ACCH = 8'h08;
    localparam logic [7:0] FL_PV   = 8'h10;
    localparam logic [7:0] FL_WAKE = 8'h20;
    localparam logic [7:0] FL_FULL = 8'h40;
    localparam logic [7:0] FL_CFG  = 8'h80;
    localparam logic [7:0] FL_PORTS = FL_USB | FL_DC | FL_AC;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    results_pending;

    int                    cycle_count;
    bit                    s_busy;
    int                    burst_left;
    bit                    rx_hold_req;
    rx_mode_t              rx_mode;
    int                    rx_mode_left;
    int                    rx_phase;
    bit [2:0]              port_loaded;
    logic [POWER_W-1:0]    dc_thr;
    logic [POWER_W-1:0]    ac_thr;

    port_idle_auto_off_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pia_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic pia_item_t mk(input logic [POWER_W-1:0] usb_p,
                                     input logic [POWER_W-1:0] dc_p,
                                     input logic [POWER_W-1:0] ac_p,
                                     input logic [7:0] flags);
        return pia_item_t'({flags, ac_p, dc_p, usb_p});
    endfunction

    // Power just around the threshold, on the side the port's load state asks for.
    function automatic logic [POWER_W-1:0] pick_power(input bit loaded,
                                                      input logic [POWER_W-1:0] thr);
        int lo;
        int hi;
        if ($urandom_range(0, 9) == 0)
            return POWER_W'($urandom_range(0, POWER_MAX));
        if (loaded || thr == 0)
        begin
            lo = int'(thr);
            hi = ($urandom_range(0, 3) == 0 || thr > POWER_MAX - 4) ? POWER_MAX : thr + 4;
        end
        else
        begin
            hi = thr - 1;
            lo = (thr > 6 && $urandom_range(0, 3) != 0) ? thr - 6 : 0;
        end
        return POWER_W'($urandom_range(lo, hi));
    endfunction

    function automatic pia_item_t rand_item(input bit charge_only);
        pia_item_t it;
        for (int p = 0; p < 3; p++)
        begin
            if ($urandom_range(0, 7) == 0)
                port_loaded[p] = ~port_loaded[p];
        end
        it.usb_power = pick_power(port_loaded[EN_USB], dc_thr);
        it.dc_power  = pick_power(port_loaded[EN_DC], dc_thr);
        it.ac_power  = pick_power(port_loaded[EN_AC], ac_thr);
        if (charge_only)
        begin
            it.usb_active  = ($urandom_range(0, 9) == 0);
            it.dc_active   = ($urandom_range(0, 9) == 0);
            it.ac_active   = ($urandom_range(0, 9) == 0);
            it.ac_charging = 1'($urandom_range(0, 1));
            it.pv_charging = it.ac_charging ? 1'($urandom_range(0, 1)) :
                                              ($urandom_range(0, 9) != 0);
            it.other_wake  = ($urandom_range(0, 19) == 0);
            it.pack_full   = ($urandom_range(0, 11) != 0);
        end
        else
        begin
            it.usb_active  = ($urandom_range(0, 9) != 0);
            it.dc_active   = ($urandom_range(0, 9) != 0);
            it.ac_active   = ($urandom_range(0, 9) != 0);
            it.ac_charging = 1'($urandom_range(0, 1));
            it.pv_charging = 1'($urandom_range(0, 1));
            it.other_wake  = 1'($urandom_range(0, 1));
            it.pack_full   = 1'($urandom_range(0, 1));
        end
        it.config_mode = ($urandom_range(0, 24) == 0);
        return it;
    endfunction

    function automatic logic [IDLE_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return IDLE_MAX;
            2:       return IDLE_W'($urandom());
            default: return IDLE_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [POWER_W-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return POWER_TOP;
            2:       return POWER_W'($urandom_range(0, POWER_MAX));
            default: return POWER_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Sends one item, opening a new burst with a random gap when the last one ran out.
    task automatic offer_tick(input pia_item_t item);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0 && s_busy)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_busy = 1'b0;
            gap--;
        end
        repeat (gap) @(negedge clk);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - $bits(pia_item_t)){1'b0}}, item};
        s_busy = 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        if (s_busy)
            s_tvalid <= 1'b0;
        s_busy = 1'b0;
        while (results_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DC_THRESHOLD)
            dc_thr = val[POWER_W-1:0];
        if (idx == CFG_AC_THRESHOLD)
            ac_thr = val[POWER_W-1:0];
    endtask

    task automatic load_settings(input logic [IDLE_W-1:0] usb_lim,
                                 input logic [IDLE_W-1:0] dc_lim,
                                 input logic [IDLE_W-1:0] ac_lim,
                                 input logic [MASK_W-1:0] mask,
                                 input logic [POWER_W-1:0] dc_level,
                                 input logic [POWER_W-1:0] ac_level,
                                 input logic [WAIT_W-1:0] wait_lim);
        write_reg(CFG_USB_IDLE_LIMIT, usb_lim);
        write_reg(CFG_DC_IDLE_LIMIT, dc_lim);
        write_reg(CFG_AC_IDLE_LIMIT, ac_lim);
        write_reg(CFG_ENABLE_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_DC_THRESHOLD, CFG_DATA_W'(dc_level));
        write_reg(CFG_AC_THRESHOLD, CFG_DATA_W'(ac_level));
        write_reg(CFG_FULL_WAIT, CFG_DATA_W'(wait_lim));
    endtask

    // Receiver: changes its stall pattern now and then, and holds off for a long
    // stretch when asked so that the block backs up into its input.
    initial
    begin
        m_tready     = 1'b0;
        rx_mode      = RX_ALWAYS;
        rx_mode_left = 0;
        rx_phase     = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = rx_mode_t'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(20, 120);
                end
                rx_mode_left--;
                rx_phase++;
                case (rx_mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:  m_tready <= ($urandom_range(0, 6) != 0);
                    RX_PATTERN: m_tready <= (rx_phase % 5 < 3);
                endcase
            end
        end
    end

    initial
    begin
        int  sent;
        int  phase;
        int  phase_items;
        int  block_left;
        bit  charge_only;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_USB_IDLE_LIMIT;
        cfg_data    = '0;
        cycle_count = 0;
        s_busy      = 1'b0;
        burst_left  = 0;
        rx_hold_req = 1'b0;
        port_loaded = '0;
        dc_thr      = DC_THRESH_RST;
        ac_thr      = AC_THRESH_RST;
        block_left  = 0;
        charge_only = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Defaults after reset: field extremes and a frozen tick.
        offer_tick(mk(0, 0, 0, 8'h00));
        offer_tick(mk(POWER_TOP, POWER_TOP, POWER_TOP, ~FL_CFG));
        offer_tick(mk(POWER_TOP, POWER_TOP, POWER_TOP, 8'hFF));
        offer_tick(mk(0, 0, 0, FL_PORTS));

        // Tiny limits and top thresholds: switch-offs, inverter clear, sleep, load clear.
        drain();
        load_settings(0, 2, 0, 3'b111, POWER_TOP, POWER_TOP, 0);
        offer_tick(mk(0, 0, 0, FL_PORTS));
        offer_tick(mk(0, 0, 0, FL_PORTS | FL_ACCH | FL_FULL));
        offer_tick(mk(0, 0, 0, FL_PORTS | FL_ACCH | FL_FULL));
        offer_tick(mk(0, 0, 0, FL_PV | FL_FULL));
        offer_tick(mk(0, 0, 0, FL_PV | FL_FULL | FL_WAKE));
        offer_tick(mk(0, 0, 0, FL_PV | FL_FULL | FL_CFG));
        repeat (7) offer_tick(mk(POWER_TOP, POWER_TOP, POWER_TOP, FL_PORTS));

        // Wait counter runs into its top, first with the largest limit, then one below.
        drain();
        write_reg(CFG_FULL_WAIT, CFG_DATA_W'(WAIT_MAX));
        repeat (300)
            offer_tick(mk(POWER_W'($urandom_range(0, POWER_MAX)),
                          POWER_W'($urandom_range(0, POWER_MAX)),
                          POWER_W'($urandom_range(0, POWER_MAX)),
                          FL_PV | FL_FULL | ($urandom_range(0, 1) ? FL_ACCH : 8'h00)));
        drain();
        write_reg(CFG_FULL_WAIT, CFG_DATA_W'(WAIT_MAX - 1'b1));
        repeat (5) offer_tick(mk(0, 0, 0, FL_PV | FL_FULL));

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            load_settings(pick_limit(), pick_limit(), pick_limit(),
                          ($urandom_range(0, 2) == 0) ? MASK_W'($urandom_range(0, 7)) : 3'b111,
                          pick_threshold(), pick_threshold(),
                          ($urandom_range(0, 3) == 0) ? WAIT_W'($urandom_range(0, WAIT_MAX)) :
                          ($urandom_range(0, 3) == 0) ? WAIT_MAX :
                                                        WAIT_W'($urandom_range(0, 15)));
            if (phase == 1 || phase == 4)
                rx_hold_req = 1'b1;
            phase_items = $urandom_range(100, 220);
            repeat (phase_items)
            begin
                if (block_left == 0)
                begin
                    block_left  = $urandom_range(10, 60);
                    charge_only = ($urandom_range(0, 3) == 0);
                end
                block_left--;
                offer_tick(rand_item(charge_only));
            end
            sent += phase_items;
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/pia_pkg.sv
rtl/pia_cfg_regs.sv
rtl/pia_port.sv
rtl/port_idle_auto_off_top.sv
sim/pia_checker.sv
sim/tb_port_idle_auto_off_top.sv
